// ===== src/assert_macros.svh =====
// assertion helpers for the rtl files
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// ===== src/csvt_pkg.sv =====
// types and constants of the csv cell tokenizer
// no dependencies; imported by every module of the block
package csvt_pkg;

  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;

  localparam int unsigned COL_W       = 9;
  localparam int unsigned MAX_COLUMNS = 256;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BLANK  = 2'd1;
  localparam logic [1:0] STATUS_UNTERM = 2'd2;
  localparam logic [1:0] STATUS_EXTRA  = 2'd3;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_CELL_END = 2'd1,
    KIND_LINE_END = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PS_START  = 3'd0,
    PS_UNQ    = 3'd1,
    PS_QUOTED = 3'd2,
    PS_QSEEN  = 3'd3,
    PS_STRAY  = 3'd4
  } parse_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [7:0]  column;
    logic        was_quoted;
    logic        is_empty;
    logic [1:0]  status;
    logic [15:0] extra_cells;
    logic        last;
  } out_item_t;

  typedef struct packed {
    parse_state_e     pstate;
    logic             pending_cr;
    logic             line_nonempty;
    logic             cell_nonempty;
    logic [COL_W-1:0] column_index;
    logic [15:0]      extra_count;
  } tok_state_t;

  // results of one input byte, item0 delivered first
  typedef struct packed {
    logic [1:0] count;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

endpackage

// ===== src/csv_cell_tokenizer.sv =====
// CSV data-row tokenizer, one byte a cycle unless stalled: cell bytes, cell
// ends, line ends. One input byte register, the parse step and a two-entry
// result queue.
// in channel: in_valid_i / in_ready_o carry data_byte and flush. A newline
// or a flush ends the line; a carriage return right before the line end
// is dropped. out channel: out_valid_o / out_ready_i carry one result
// (cell byte, cell end or line end with status); last marks the final
// result of an input byte. cfg channel: cfg_valid_i / cfg_ready_o write
// column_count; always ready. It must be written only while the block is
// idle, a rule for the user that the block does not enforce. A byte's
// results pass the input register and the result queue before being taken.
// Throughput: one byte per cycle while the receiver is ready and each byte
// gives at most one result. A byte giving two results waits in the input
// register until the queue is empty, and the byte after it waits for space;
// free queue space sets the rate. A stalled receiver fills the queue and
// then holds the input register; in_ready_o drops only once it is full too.
// Reset clears the parser to the start of a line, empties the queue and
// sets column_count to 1.
`include "assert_macros.svh"

module csv_cell_tokenizer import csvt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_data_i
);

  logic [8:0]       cfg_q;
  logic [COL_W-1:0] cols;
  logic             in_valid_q;
  in_item_t         in_data_q;
  push_t            push;
  logic [1:0]       free;
  logic             fire;

  always_comb begin
    cols = cfg_q;
    if (cols < COL_W'(1))           cols = COL_W'(1);
    if (cols > COL_W'(256))         cols = COL_W'(256);
    if (cols > COL_W'(MAX_COLUMNS)) cols = COL_W'(MAX_COLUMNS);
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 9'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  assign fire       = in_valid_q && (push.count <= free);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_data_q <= in_data_i;
  end

  csvt_step_logic u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_data_q),
    .cols_i (cols),
    .fire_i (fire),
    .push_o (push)
  );

  csvt_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (fire),
    .push_i      (push),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `ASSERT_CLK(a_push_fits, clk_i, rst_ni, fire |-> (push.count <= free), "queue overflow")
  `ASSERT_CLK(a_line_end_last, clk_i, rst_ni,
              (out_valid_o && out_data_o.kind == KIND_LINE_END) |-> out_data_o.last,
              "line end result not marked last")
  `ASSERT_CLK(a_held_byte, clk_i, rst_ni,
              (in_valid_q && !fire) |=> (in_valid_q && $stable(in_data_q)),
              "waiting input byte lost")
  `ASSERT_NEVER(a_two_need_empty, clk_i, rst_ni,
                fire && push.count == 2'd2 && out_valid_o, "two results pushed into busy queue")

endmodule

// ===== src/csvt_step_logic.sv =====
// parser state register and the per-byte tokenizing logic
// depends on csvt_pkg
module csvt_step_logic import csvt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_item_t         item_i,
  input  logic [COL_W-1:0] cols_i,
  input  logic             fire_i,
  output push_t            push_o
);

  typedef struct packed {
    tok_state_t st;
    logic       emit;
    out_item_t  res;
  } proc_t;

  typedef struct packed {
    tok_state_t st;
    push_t      push;
  } step_t;

  tok_state_t state_q, state_d;

  function automatic out_item_t mk_item(kind_e k, logic [7:0] b, logic [7:0] c, logic q,
                                        logic e, logic [1:0] st, logic [15:0] ex);
    out_item_t r;
    r.kind        = k;
    r.out_byte    = b;
    r.column      = c;
    r.was_quoted  = q;
    r.is_empty    = e;
    r.status      = st;
    r.extra_cells = ex;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic proc_t cell_byte(tok_state_t s, logic [7:0] b, logic q,
                                      logic [COL_W-1:0] cols);
    proc_t p;
    p.st   = s;
    p.emit = 1'b0;
    p.res  = '0;
    if (s.column_index < cols) begin
      p.emit = 1'b1;
      p.res  = mk_item(KIND_BYTE, b, s.column_index[7:0], q, 1'b0, STATUS_OK, 16'd0);
    end
    p.st.cell_nonempty = 1'b1;
    return p;
  endfunction

  function automatic proc_t cell_end(tok_state_t s, logic q, logic [COL_W-1:0] cols);
    proc_t p;
    p.st   = s;
    p.emit = 1'b0;
    p.res  = '0;
    if (s.column_index < cols) begin
      p.emit = 1'b1;
      p.res  = mk_item(KIND_CELL_END, 8'd0, s.column_index[7:0], q, !s.cell_nonempty,
                       STATUS_OK, 16'd0);
      p.st.column_index = s.column_index + COL_W'(1);
    end else if (s.extra_count != 16'hFFFF) begin
      p.st.extra_count = s.extra_count + 16'd1;
    end
    p.st.cell_nonempty = 1'b0;
    return p;
  endfunction

  function automatic proc_t proc_byte(tok_state_t s, logic [7:0] b, logic [COL_W-1:0] cols);
    proc_t      p;
    tok_state_t t;
    t = s;
    t.line_nonempty = 1'b1;
    p.st   = t;
    p.emit = 1'b0;
    p.res  = '0;
    unique case (t.pstate)
      PS_START: begin
        t.cell_nonempty = 1'b0;
        p.st = t;
        if (b == CH_QUOTE) begin
          p.st.pstate = PS_QUOTED;
        end else if (b == CH_COMMA) begin
          p = cell_end(t, 1'b0, cols);
        end else begin
          p = cell_byte(t, b, 1'b0, cols);
          p.st.pstate = PS_UNQ;
        end
      end
      PS_UNQ: begin
        if (b == CH_COMMA) begin
          p = cell_end(t, 1'b0, cols);
          p.st.pstate = PS_START;
        end else begin
          p = cell_byte(t, b, 1'b0, cols);
        end
      end
      PS_QUOTED: begin
        if (b == CH_QUOTE) p.st.pstate = PS_QSEEN;
        else               p = cell_byte(t, b, 1'b1, cols);
      end
      PS_QSEEN: begin
        if (b == CH_QUOTE) begin
          p = cell_byte(t, CH_QUOTE, 1'b1, cols);
          p.st.pstate = PS_QUOTED;
        end else if (b == CH_COMMA) begin
          p = cell_end(t, 1'b1, cols);
          p.st.pstate = PS_START;
        end else begin
          p = cell_end(t, 1'b1, cols);
          p.st.pstate = PS_STRAY;
        end
      end
      default: begin
        // skipping stray bytes after a closing quote
        if (b == CH_COMMA) p.st.pstate = PS_START;
      end
    endcase
    return p;
  endfunction

  function automatic step_t line_end(tok_state_t s, logic [COL_W-1:0] cols);
    step_t      r;
    proc_t      ce;
    tok_state_t t;
    out_item_t  le;
    logic [1:0] st;
    t      = s;
    r.push = '0;
    ce     = '0;
    if (!t.line_nonempty) begin
      r.push.count = 2'd1;
      r.push.item0 = mk_item(KIND_LINE_END, 8'd0, 8'd0, 1'b0, 1'b0, STATUS_BLANK, 16'd0);
    end else begin
      unique case (t.pstate)
        PS_START: begin
          t.cell_nonempty = 1'b0;
          ce = cell_end(t, 1'b0, cols);
          t  = ce.st;
        end
        PS_UNQ: begin
          ce = cell_end(t, 1'b0, cols);
          t  = ce.st;
        end
        PS_QSEEN: begin
          ce = cell_end(t, 1'b1, cols);
          t  = ce.st;
        end
        default: ;
      endcase
      priority if (t.pstate == PS_QUOTED) st = STATUS_UNTERM;
      else if (t.extra_count != 16'd0)    st = STATUS_EXTRA;
      else                                st = STATUS_OK;
      le = mk_item(KIND_LINE_END, 8'd0, 8'd0, 1'b0, 1'b0, st, t.extra_count);
      if (ce.emit) begin
        r.push.count = 2'd2;
        r.push.item0 = ce.res;
        r.push.item1 = le;
      end else begin
        r.push.count = 2'd1;
        r.push.item0 = le;
      end
    end
    r.st.pstate        = PS_START;
    r.st.pending_cr    = 1'b0;
    r.st.line_nonempty = 1'b0;
    r.st.cell_nonempty = 1'b0;
    r.st.column_index  = '0;
    r.st.extra_count   = 16'd0;
    return r;
  endfunction

  step_t      le_s;
  proc_t      pa, pb;
  tok_state_t t;
  push_t      push;

  always_comb begin
    le_s    = line_end(state_q, cols_i);
    pa      = '0;
    pb      = '0;
    t       = state_q;
    push    = '0;
    state_d = state_q;
    priority if (item_i.flush) begin
      if (state_q.line_nonempty || state_q.pending_cr) begin
        state_d = le_s.st;
        push    = le_s.push;
      end
    end else if (item_i.data_byte == CH_LF) begin
      state_d = le_s.st;
      push    = le_s.push;
    end else begin
      // a held carriage return goes in as content ahead of this byte
      if (t.pending_cr) begin
        t.pending_cr = 1'b0;
        pa = proc_byte(t, CH_CR, cols_i);
        t  = pa.st;
      end
      if (item_i.data_byte == CH_CR) begin
        t.pending_cr = 1'b1;
      end else begin
        pb = proc_byte(t, item_i.data_byte, cols_i);
        t  = pb.st;
      end
      state_d = t;
      if (pa.emit && pb.emit) begin
        push.count = 2'd2;
        push.item0 = pa.res;
        push.item1 = pb.res;
      end else if (pa.emit) begin
        push.count = 2'd1;
        push.item0 = pa.res;
      end else if (pb.emit) begin
        push.count = 2'd1;
        push.item0 = pb.res;
      end
    end
    if (push.count == 2'd1) push.item0.last = 1'b1;
    if (push.count == 2'd2) push.item1.last = 1'b1;
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{pstate: PS_START, pending_cr: 1'b0, line_nonempty: 1'b0,
                   cell_nonempty: 1'b0, column_index: '0, extra_count: 16'd0};
    end else if (fire_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/csvt_out_queue.sv =====
// two-entry result queue, takes up to two items a cycle, hands out one
// depends on csvt_pkg
module csvt_out_queue import csvt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_en_i,
  input  push_t      push_i,
  output logic [1:0] free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o
);

  out_item_t  q0_q, q0_d, q1_q, q1_d, shifted0;
  logic [1:0] cnt_q, cnt_d, base;
  logic       pop;

  assign pop      = (cnt_q != 2'd0) && out_ready_i;
  assign shifted0 = pop ? q1_q : q0_q;
  assign base     = cnt_q - {1'b0, pop};

  always_comb begin
    q0_d  = (base != 2'd0) ? shifted0 : push_i.item0;
    q1_d  = (base == 2'd2) ? q1_q : ((base == 2'd1) ? push_i.item0 : push_i.item1);
    cnt_d = base + (push_en_i ? push_i.count : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q <= q0_d;
    q1_q <= q1_d;
  end

  // free space does not count this cycle's transaction, keeping ready registered
  assign free_o      = 2'd2 - cnt_q;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = q0_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for csv_cell_tokenizer: directed and random csv rows checked token by token
// depends on csvt_pkg and the csv_cell_tokenizer rtl; the predictor lives in a small class
module tb_top;
  import csvt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WIDE_COMMAS    = 257;
  localparam int unsigned PHASE_ITEMS    = 26;

  // predicts the token stream of the tokenizer and checks the dut against it
  class token_scoreboard;
    logic [8:0]   column_count;
    parse_state_e pstate;
    bit           pending_cr;
    bit           line_nonempty;
    bit           cell_nonempty;
    int unsigned  col_idx;
    int unsigned  extra_cnt;
    out_item_t    expected_tokens[$];
    out_item_t    step_tokens[$];
    int unsigned  errors;
    int unsigned  inputs_seen;
    int unsigned  tokens_checked;
    int unsigned  line_status_cnt[4];

    function new();
      column_count   = 9'd1;
      pstate         = PS_START;
      pending_cr     = 1'b0;
      line_nonempty  = 1'b0;
      cell_nonempty  = 1'b0;
      col_idx        = 0;
      extra_cnt      = 0;
      errors         = 0;
      inputs_seen    = 0;
      tokens_checked = 0;
      foreach (line_status_cnt[i]) line_status_cnt[i] = 0;
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction

    function int unsigned eff_columns();
      int unsigned c;
      c = column_count;
      if (c < 1) c = 1;
      if (c > 256) c = 256;
      if (c > MAX_COLUMNS) c = MAX_COLUMNS;
      return c;
    endfunction

    function void push_token(kind_e k, logic [7:0] b, logic q, logic e, logic [1:0] st,
                             logic [15:0] ex);
      out_item_t t;
      t = '0;
      t.kind        = k;
      t.out_byte    = b;
      t.column      = (k == KIND_LINE_END) ? 8'd0 : 8'(col_idx);
      t.was_quoted  = q;
      t.is_empty    = e;
      t.status      = st;
      t.extra_cells = ex;
      t.last        = 1'b0;
      step_tokens = {step_tokens, t};
    endfunction

    function void add_cell_byte(logic [7:0] b, logic q);
      if (col_idx < eff_columns()) push_token(KIND_BYTE, b, q, 1'b0, STATUS_OK, 16'd0);
      cell_nonempty = 1'b1;
    endfunction

    // cells past the column count are only counted
    function void close_cell(logic q);
      if (col_idx < eff_columns()) begin
        push_token(KIND_CELL_END, 8'd0, q, !cell_nonempty, STATUS_OK, 16'd0);
        col_idx++;
      end else if (extra_cnt < 65535) begin
        extra_cnt++;
      end
      cell_nonempty = 1'b0;
    endfunction

    function void parse_byte(logic [7:0] b);
      line_nonempty = 1'b1;
      case (pstate)
        PS_START: begin
          cell_nonempty = 1'b0;
          if (b == CH_QUOTE) begin
            pstate = PS_QUOTED;
          end else if (b == CH_COMMA) begin
            close_cell(1'b0);
          end else begin
            add_cell_byte(b, 1'b0);
            pstate = PS_UNQ;
          end
        end
        PS_UNQ: begin
          if (b == CH_COMMA) begin
            close_cell(1'b0);
            pstate = PS_START;
          end else begin
            add_cell_byte(b, 1'b0);
          end
        end
        PS_QUOTED: begin
          if (b == CH_QUOTE) pstate = PS_QSEEN;
          else add_cell_byte(b, 1'b1);
        end
        PS_QSEEN: begin
          if (b == CH_QUOTE) begin
            add_cell_byte(CH_QUOTE, 1'b1);
            pstate = PS_QUOTED;
          end else if (b == CH_COMMA) begin
            close_cell(1'b1);
            pstate = PS_START;
          end else begin
            close_cell(1'b1);
            pstate = PS_STRAY;
          end
        end
        default: begin
          if (b == CH_COMMA) pstate = PS_START;
        end
      endcase
    endfunction

    function void close_line();
      logic [1:0] st;
      st = STATUS_OK;
      pending_cr = 1'b0;
      if (!line_nonempty) begin
        push_token(KIND_LINE_END, 8'd0, 1'b0, 1'b0, STATUS_BLANK, 16'd0);
        line_status_cnt[STATUS_BLANK]++;
      end else begin
        case (pstate)
          PS_START: begin
            cell_nonempty = 1'b0;
            close_cell(1'b0);
          end
          PS_UNQ:   close_cell(1'b0);
          PS_QSEEN: close_cell(1'b1);
          default: ;
        endcase
        // an open quote outranks extra cells
        if (pstate == PS_QUOTED) st = STATUS_UNTERM;
        else if (extra_cnt != 0) st = STATUS_EXTRA;
        push_token(KIND_LINE_END, 8'd0, 1'b0, 1'b0, st, 16'(extra_cnt));
        line_status_cnt[st]++;
      end
      pstate        = PS_START;
      line_nonempty = 1'b0;
      cell_nonempty = 1'b0;
      col_idx       = 0;
      extra_cnt     = 0;
    endfunction

    function void note_input(in_item_t it);
      inputs_seen++;
      if (it.flush) begin
        if (line_nonempty || pending_cr) close_line();
      end else if (it.data_byte == CH_LF) begin
        close_line();
      end else begin
        // a held carriage return turns into content once another byte follows
        if (pending_cr) begin
          pending_cr = 1'b0;
          parse_byte(CH_CR);
        end
        if (it.data_byte == CH_CR) pending_cr = 1'b1;
        else parse_byte(it.data_byte);
      end
      if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      expected_tokens = {expected_tokens, step_tokens};
      step_tokens.delete();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("mismatch: %s", msg);
    endtask

    task cmp_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("token %0d %s got %0h expected %0h", tokens_checked, name, got, want));
    endtask

    task check_token(out_item_t got);
      out_item_t want;
      tokens_checked++;
      if (expected_tokens.size() == 0) begin
        report($sformatf("token %0d of kind %0d arrived with nothing expected",
                         tokens_checked, got.kind));
        return;
      end
      want = expected_tokens.pop_front();
      cmp_field("kind", 16'(got.kind), 16'(want.kind));
      cmp_field("out_byte", 16'(got.out_byte), 16'(want.out_byte));
      cmp_field("column", 16'(got.column), 16'(want.column));
      cmp_field("was_quoted", 16'(got.was_quoted), 16'(want.was_quoted));
      cmp_field("is_empty", 16'(got.is_empty), 16'(want.is_empty));
      cmp_field("status", 16'(got.status), 16'(want.status));
      cmp_field("extra_cells", got.extra_cells, want.extra_cells);
      cmp_field("last", 16'(got.last), 16'(want.last));
    endtask
  endclass

  logic        clk;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data  = '0;

  bit          hold_arm    = 1'b0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned cur_columns = 1;
  in_item_t    row_q[$];
  token_scoreboard sb;

  csv_cell_tokenizer dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_ni && cfg_valid && cfg_ready) sb.column_count = cfg_data;
    if (rst_ni && in_valid && in_ready) sb.note_input(in_data);
    if (rst_ni && out_valid && out_ready) sb.check_token(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver: segments of random ready patterns, plus one long hold on request
  initial begin : receiver
    int unsigned seg_left;
    int unsigned mode;
    seg_left = 0;
    mode     = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_arm) begin
        hold_arm = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 80);
      end
      seg_left--;
      @(negedge clk);
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // sender works in bursts with short gaps between them
  task send_item(in_item_t it);
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task send_byte(logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.flush     = 1'b0;
    send_item(it);
  endtask

  task send_flush();
    in_item_t it;
    it.data_byte = 8'($urandom_range(0, 255));
    it.flush     = 1'b1;
    send_item(it);
  endtask

  task send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_columns(logic [8:0] n);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_columns = n;
  endtask

  function automatic logic [7:0] content_byte(bit quoted);
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(32, 126));
      else b = 8'($urandom_range(0, 255));
    end while (b == CH_LF || b == CH_QUOTE || (!quoted && b == CH_COMMA));
    return b;
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.flush     = 1'b0;
    row_q = {row_q, it};
  endfunction

  function automatic void queue_flush();
    in_item_t it;
    it.data_byte = 8'($urandom_range(0, 255));
    it.flush     = 1'b1;
    row_q = {row_q, it};
  endfunction

  // row with random content, some malformed cells and a random kind of line end
  function automatic void build_row(int unsigned ncells, int unsigned max_len);
    int unsigned c;
    int unsigned i;
    int unsigned len;
    int unsigned pick;
    for (c = 0; c < ncells; c++) begin
      if (c != 0) queue_byte(CH_COMMA);
      len = $urandom_range(0, max_len);
      if ($urandom_range(0, 9) < 6) begin
        for (i = 0; i < len; i++) begin
          if (i != 0 && $urandom_range(0, 19) == 0) queue_byte(CH_QUOTE);
          else queue_byte(content_byte(1'b0));
        end
      end else begin
        queue_byte(CH_QUOTE);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 6) == 0) begin
            queue_byte(CH_QUOTE);
            queue_byte(CH_QUOTE);
          end else begin
            queue_byte(content_byte(1'b1));
          end
        end
        queue_byte(CH_QUOTE);
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 2)) queue_byte(content_byte(1'b0));
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      queue_byte(CH_LF);
    end else if (pick < 80) begin
      queue_byte(CH_CR);
      queue_byte(CH_LF);
    end else if (pick < 93) begin
      queue_flush();
    end else begin
      // open a quoted cell that never closes
      if (ncells != 0) queue_byte(CH_COMMA);
      queue_byte(CH_QUOTE);
      repeat ($urandom_range(0, 3)) queue_byte(content_byte(1'b1));
      queue_byte(CH_LF);
    end
  endfunction

  function automatic void build_noise();
    int unsigned i;
    int unsigned len;
    len = $urandom_range(0, 12);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) < 4) begin
        case ($urandom_range(0, 3))
          0:       queue_byte(CH_COMMA);
          1:       queue_byte(CH_QUOTE);
          2:       queue_byte(CH_CR);
          default: queue_byte(CH_LF);
        endcase
      end else begin
        queue_byte(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 1) != 0) queue_byte(CH_LF);
    else queue_flush();
  endfunction

  task send_queued(inout int unsigned sent);
    in_item_t it;
    while (row_q.size() != 0) begin
      it = row_q.pop_front();
      send_item(it);
      sent++;
    end
  endtask

  task run_rows(int unsigned n_items);
    int unsigned sent;
    int unsigned c;
    int unsigned bound;
    sent = 0;
    c = cur_columns;
    if (c < 1) c = 1;
    if (c > 256) c = 256;
    bound = (c < 8) ? c + 2 : 9;
    while (sent < n_items) begin
      if ($urandom_range(0, 6) == 0) build_noise();
      else build_row($urandom_range(0, bound), 4);
      send_queued(sent);
    end
  endtask

  initial begin : stimulus
    logic [8:0]  col_settings[8];
    int unsigned sent;
    int i;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    write_columns(9'd3);
    send_text("\n");                   // blank line
    send_text("\015\n");               // cr dropped, still blank
    send_flush();                      // flush with nothing on the line
    send_byte(8'h00);
    send_text(",\n");                  // trailing comma
    send_text("\"q\"\"\"z\n");         // escaped quote, stray byte up to line end
    send_text("\"u\n");                // unterminated quote
    send_byte(8'hFF);
    send_text("\"\015b,,,\n");         // quote and cr as content, one extra cell
    send_text("\015");
    send_flush();                      // held cr then flush

    col_settings = '{9'd2, 9'd256, 9'd0, 9'd5, 9'd511, 9'd1, 9'd3, 9'd7};
    col_settings[7] = 9'($urandom_range(1, 12));
    sent = 0;
    for (i = 0; i < 8; i++) begin
      write_columns(col_settings[i]);
      if (i == 0) hold_arm = 1'b1;
      run_rows(PHASE_ITEMS);
      // a wide row of empty cells reaches the top column indexes and two extras
      if (col_settings[i] == 9'd256) begin
        repeat (WIDE_COMMAS) queue_byte(CH_COMMA);
        queue_byte(CH_LF);
        send_queued(sent);
      end
    end
    wait_idle();

    $display("run covered %0d input transactions and %0d result tokens",
             sb.inputs_seen, sb.tokens_checked);
    $display("line ends: %0d ok, %0d blank, %0d unterminated, %0d with extra cells",
             sb.line_status_cnt[STATUS_OK], sb.line_status_cnt[STATUS_BLANK],
             sb.line_status_cnt[STATUS_UNTERM], sb.line_status_cnt[STATUS_EXTRA]);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
